FILE: sv/sqrt_overdrive_lowpass_assert.svh
// Assertion macros used by the checker of the square-root overdrive block.
`ifndef SQRT_OVERDRIVE_LOWPASS_ASSERT_SVH
`define SQRT_OVERDRIVE_LOWPASS_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define SOL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define SOL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sol_pkg.sv
// Shared types and constants of the square-root overdrive lowpass block.
package sol_pkg;

    // Filter state width and output gain format.
    localparam int STATE_BITS     = 32;
    localparam int GAIN_W         = 16;
    localparam int GAIN_FRAC_BITS = 12;

    // Configuration register indexes.
    localparam int          CFG_IDX_W = 2;
    localparam logic [1:0]  CFG_DRIVE = 2'd0;
    localparam logic [1:0]  CFG_COEF  = 2'd1;
    localparam logic [1:0]  CFG_GAIN  = 2'd2;

    // Sequencer states, one pass per channel from S_LOAD to S_OUTS.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_ROOT,
        S_DIFF,
        S_MULD,
        S_MIX,
        S_FDIF,
        S_MULF,
        S_FUPD,
        S_MULG,
        S_OUTS,
        S_DONE
    } t_state;

endpackage

FILE: sv/sqrt_overdrive_lowpass.sv
// Stereo square-root overdrive with one-pole lowpass and output gain.
//
// One request carries a stereo sample pair (left in the low tdata bits). The channels are
// processed one after the other by a small sequencer: a restoring square root that yields
// one root bit per cycle, then three products on one shared signed multiplier for the drive
// blend, the lowpass update and the output gain. Each channel passes the states S_LOAD to
// S_OUTS in turn, and a stereo pair occupies the block from one accepted request to the
// next, most of that time in the root loop. s_axis_tready is high only while the sequencer
// is idle. The result sits in an output register, so a new pair is accepted while the
// previous result waits. The filter state of both channels is cleared by reset.
// Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_wdata; the user must
// do so only while the block is idle, which the block itself does not enforce. Indexes
// beyond the register list are ignored.
module sqrt_overdrive_lowpass #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16,
    localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int CFG_W  = (COEF_FRAC_BITS + 1 > sol_pkg::GAIN_W) ?
                            COEF_FRAC_BITS + 1 : sol_pkg::GAIN_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [sol_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_wdata,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [DATA_W-1:0]             s_axis_tdata,  // left_sample, right_sample
    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [DATA_W-1:0]             m_axis_tdata   // left_result, right_result
);

    localparam int SB      = SAMPLE_BITS;
    localparam int CF      = COEF_FRAC_BITS;
    localparam int COEF_W  = CF + 1;
    localparam int ST_W    = sol_pkg::STATE_BITS;
    localparam int EXTRA   = ST_W - SB;
    localparam int RAD_W   = 2 * SB;
    localparam int REM_W   = SB + 2;
    localparam int TRY_W   = SB + 4;
    localparam int CNT_W   = $clog2(SB);
    localparam int MUL_AW  = (CF + 2 > sol_pkg::GAIN_W + 1) ? CF + 2 : sol_pkg::GAIN_W + 1;
    localparam int MUL_BW  = ST_W + 2;
    localparam int PROD_W  = MUL_AW + MUL_BW;
    localparam int OUT_SH  = sol_pkg::GAIN_FRAC_BITS + EXTRA;

    // Configuration registers
    logic [COEF_W-1:0]          r_drive;
    logic [COEF_W-1:0]          r_coef;
    logic [sol_pkg::GAIN_W-1:0] r_gain;

    // Sequencer
    sol_pkg::t_state r_state, n_state;
    logic            r_ch, n_ch;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Datapath registers
    logic signed [SB-1:0]     r_in_l, n_in_l, r_in_r, n_in_r;
    logic signed [SB-1:0]     r_x, n_x;
    logic [RAD_W-1:0]         r_rad, n_rad;
    logic [REM_W-1:0]         r_rem, n_rem;
    logic [SB-1:0]            r_root, n_root;
    logic signed [MUL_AW-1:0] r_opa, n_opa;
    logic signed [MUL_BW-1:0] r_opb, n_opb;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [SB:0]       r_mix, n_mix;
    logic signed [ST_W-1:0]   r_filt_l, n_filt_l, r_filt_r, n_filt_r;
    logic [SB-1:0]            r_res_l, n_res_l, r_res_r, n_res_r;
    logic [SB-1:0]            r_out_l, n_out_l, r_out_r, n_out_r;
    logic                     r_out_valid, n_out_valid;

    // Control strobes from the state decode
    logic w_in_ready;
    logic w_load_out;

    // Combinational helpers
    logic                     w_in_acc;
    logic signed [SB-1:0]     w_x_sel;
    logic [SB-1:0]            w_mag;
    logic [TRY_W-1:0]         w_rem_t;
    logic [TRY_W-1:0]         w_trial;
    logic [COEF_W-1:0]        w_drive_c;
    logic [COEF_W-1:0]        w_coef_c;
    logic signed [MUL_BW-1:0] w_x_ext;
    logic signed [MUL_BW-1:0] w_root_s;
    logic signed [MUL_BW-1:0] w_filt_ext;
    logic signed [MUL_BW-1:0] w_mix_ext;
    logic signed [PROD_W-1:0] w_prod_cf;
    logic signed [PROD_W-1:0] w_prod_out;
    logic signed [MUL_BW-1:0] w_y_wide;
    logic signed [ST_W-1:0]   w_y;
    logic [SB-1:0]            w_o;

    assign w_in_acc = s_axis_tvalid && w_in_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= '0;
            r_coef  <= COEF_W'(1) << CF;
            r_gain  <= sol_pkg::GAIN_W'(1) << sol_pkg::GAIN_FRAC_BITS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                sol_pkg::CFG_DRIVE: r_drive <= i_cfg_wdata[COEF_W-1:0];
                sol_pkg::CFG_COEF:  r_coef  <= i_cfg_wdata[COEF_W-1:0];
                sol_pkg::CFG_GAIN:  r_gain  <= i_cfg_wdata[sol_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sol_pkg::S_IDLE: if (s_axis_tvalid) n_state = sol_pkg::S_LOAD;
            sol_pkg::S_LOAD: n_state = sol_pkg::S_ROOT;
            sol_pkg::S_ROOT: if (r_cnt == '0) n_state = sol_pkg::S_DIFF;
            sol_pkg::S_DIFF: n_state = sol_pkg::S_MULD;
            sol_pkg::S_MULD: n_state = sol_pkg::S_MIX;
            sol_pkg::S_MIX:  n_state = sol_pkg::S_FDIF;
            sol_pkg::S_FDIF: n_state = sol_pkg::S_MULF;
            sol_pkg::S_MULF: n_state = sol_pkg::S_FUPD;
            sol_pkg::S_FUPD: n_state = sol_pkg::S_MULG;
            sol_pkg::S_MULG: n_state = sol_pkg::S_OUTS;
            sol_pkg::S_OUTS: n_state = r_ch ? sol_pkg::S_DONE : sol_pkg::S_LOAD;
            sol_pkg::S_DONE: if (!r_out_valid || m_axis_tready) n_state = sol_pkg::S_IDLE;
            default:         n_state = sol_pkg::S_IDLE;
        endcase
    end

    // State decode outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            sol_pkg::S_IDLE: w_in_ready = 1'b1;
            sol_pkg::S_DONE: w_load_out = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    // Operand preparation
    always_comb begin
        w_x_sel    = r_ch ? r_in_r : r_in_l;
        w_mag      = w_x_sel[SB-1] ? SB'(-w_x_sel) : SB'(w_x_sel);
        w_rem_t    = {r_rem, r_rad[RAD_W-1 -: 2]};
        w_trial    = {2'b00, r_root, 2'b01};
        w_drive_c  = r_drive[CF] ? (COEF_W'(1) << CF) : r_drive;
        w_coef_c   = r_coef[CF] ? (COEF_W'(1) << CF) : r_coef;
        w_x_ext    = {{(MUL_BW - SB){r_x[SB-1]}}, r_x};
        w_root_s   = {{(MUL_BW - SB){1'b0}}, r_root};
        w_filt_ext = r_ch ? {{(MUL_BW - ST_W){r_filt_r[ST_W-1]}}, r_filt_r}
                          : {{(MUL_BW - ST_W){r_filt_l[ST_W-1]}}, r_filt_l};
        w_mix_ext  = {{(MUL_BW - SB - 1){r_mix[SB]}}, r_mix} <<< EXTRA;
        w_prod_cf  = r_prod >>> CF;
        w_prod_out = r_prod >>> OUT_SH;
        w_y_wide   = w_filt_ext + $signed(w_prod_cf[MUL_BW-1:0]);

        // Saturate the filter value to the state width.
        if (w_y_wide[MUL_BW-1:ST_W-1] == '0 || w_y_wide[MUL_BW-1:ST_W-1] == '1) begin
            w_y = w_y_wide[ST_W-1:0];
        end else if (w_y_wide[MUL_BW-1]) begin
            w_y = {1'b1, {(ST_W - 1){1'b0}}};
        end else begin
            w_y = {1'b0, {(ST_W - 1){1'b1}}};
        end

        // Saturate the scaled output to the sample range.
        if (w_prod_out[PROD_W-1:SB-1] == '0 || w_prod_out[PROD_W-1:SB-1] == '1) begin
            w_o = w_prod_out[SB-1:0];
        end else if (w_prod_out[PROD_W-1]) begin
            w_o = {1'b1, {(SB - 1){1'b0}}};
        end else begin
            w_o = {1'b0, {(SB - 1){1'b1}}};
        end
    end

    // Datapath next values
    always_comb begin
        n_ch        = r_ch;
        n_cnt       = r_cnt;
        n_in_l      = r_in_l;
        n_in_r      = r_in_r;
        n_x         = r_x;
        n_rad       = r_rad;
        n_rem       = r_rem;
        n_root      = r_root;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_prod      = r_prod;
        n_mix       = r_mix;
        n_filt_l    = r_filt_l;
        n_filt_r    = r_filt_r;
        n_res_l     = r_res_l;
        n_res_r     = r_res_r;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;
        n_out_valid = r_out_valid && !m_axis_tready;

        case (r_state)
            // Capture the stereo pair.
            sol_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_in_l = $signed(s_axis_tdata[SB-1:0]);
                    n_in_r = $signed(s_axis_tdata[2*SB-1:SB]);
                    n_ch   = 1'b0;
                end
            end
            // Radicand is the magnitude scaled up by SB - 1 bits.
            sol_pkg::S_LOAD: begin
                n_x    = w_x_sel;
                n_rad  = {1'b0, w_mag, {(SB - 1){1'b0}}};
                n_rem  = '0;
                n_root = '0;
                n_cnt  = CNT_W'(SB - 1);
            end
            // One restoring root step: two radicand bits in, one root bit out.
            sol_pkg::S_ROOT: begin
                if (w_rem_t >= w_trial) begin
                    n_rem  = REM_W'(w_rem_t - w_trial);
                    n_root = {r_root[SB-2:0], 1'b1};
                end else begin
                    n_rem  = w_rem_t[REM_W-1:0];
                    n_root = {r_root[SB-2:0], 1'b0};
                end
                n_rad = r_rad << 2;
                n_cnt = r_cnt - CNT_W'(1);
            end
            // Drive blend operands: drive * (root - dry).
            sol_pkg::S_DIFF: begin
                n_opa = $signed({{(MUL_AW - COEF_W){1'b0}}, w_drive_c});
                n_opb = (r_x[SB-1] ? -w_root_s : w_root_s) - w_x_ext;
            end
            sol_pkg::S_MULD, sol_pkg::S_MULF, sol_pkg::S_MULG: begin
                n_prod = r_opa * r_opb;
            end
            sol_pkg::S_MIX: begin
                n_mix = $signed(w_x_ext[SB:0] + w_prod_cf[SB:0]);
            end
            // Lowpass operands: f * (mix - y) on the state scale.
            sol_pkg::S_FDIF: begin
                n_opa = $signed({{(MUL_AW - COEF_W){1'b0}}, w_coef_c});
                n_opb = w_mix_ext - w_filt_ext;
            end
            // Store the new filter value and set up the gain product.
            sol_pkg::S_FUPD: begin
                if (r_ch) begin
                    n_filt_r = w_y;
                end else begin
                    n_filt_l = w_y;
                end
                n_opa = $signed({{(MUL_AW - sol_pkg::GAIN_W){1'b0}}, r_gain});
                n_opb = {{(MUL_BW - ST_W){w_y[ST_W-1]}}, w_y};
            end
            sol_pkg::S_OUTS: begin
                if (r_ch) begin
                    n_res_r = w_o;
                end else begin
                    n_res_l = w_o;
                    n_ch    = 1'b1;
                end
            end
            default: ;
        endcase

        // Hand the finished pair to the output register.
        if (w_load_out) begin
            n_out_l     = r_res_l;
            n_out_r     = r_res_r;
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sol_pkg::S_IDLE;
            r_ch        <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_filt_l    <= '0;
            r_filt_r    <= '0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_filt_l    <= n_filt_l;
            r_filt_r    <= n_filt_r;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_in_l  <= n_in_l;
        r_in_r  <= n_in_r;
        r_x     <= n_x;
        r_rad   <= n_rad;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_opa   <= n_opa;
        r_opb   <= n_opb;
        r_prod  <= n_prod;
        r_mix   <= n_mix;
        r_res_l <= n_res_l;
        r_res_r <= n_res_r;
        r_out_l <= n_out_l;
        r_out_r <= n_out_r;
    end

    assign s_axis_tready = w_in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_W'({r_out_r, r_out_l});

endmodule

FILE: sv/sol_checker.sv
// Port-level checker for the square-root overdrive block, bound to its top level.
`include "sqrt_overdrive_lowpass_assert.svh"

module sol_checker #(
    parameter int DATA_W = 48
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata
);

    logic w_out_stall;
    logic w_in_acc;

    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_in_acc    = s_axis_tvalid && s_axis_tready;

    // A stalled result keeps its valid and its data.
    `SOL_ASSERT_NXT(a_out_hold, w_out_stall, m_axis_tvalid, "result dropped while stalled")
    `SOL_ASSERT_NXT(a_out_stable, w_out_stall, $stable(m_axis_tdata), "stalled result changed")

    // An accepted request keeps the block busy for the following cycles.
    `SOL_ASSERT_NXT(a_busy_after_req, w_in_acc, !s_axis_tready ##1 !s_axis_tready, "early ready")

    // A fresh result appears exactly when the sequencer returns to idle.
    `SOL_ASSERT_IMP(a_result_idle, $rose(m_axis_tvalid), s_axis_tready, "result while busy")

endmodule

bind sqrt_overdrive_lowpass sol_checker #(.DATA_W($bits(m_axis_tdata))) u_sol_checker (.*);

FILE: verif/sqrt_overdrive_lowpass_test.sv
// Self-checking testbench for the square-root overdrive lowpass block.
module sqrt_overdrive_lowpass_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = 24;
    localparam int DATA_W   = 48;
    localparam int CFG_W    = 17;

    // Register index past the end of the list, writes to it must be dropped.
    localparam logic [sol_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Sample extremes and a few landmarks, Q1.23.
    localparam logic [SAMPLE_W-1:0] SMP_MAX     = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] SMP_MIN     = 24'h800000;
    localparam logic [SAMPLE_W-1:0] SMP_ZERO    = 24'h000000;
    localparam logic [SAMPLE_W-1:0] SMP_ONE     = 24'h000001;
    localparam logic [SAMPLE_W-1:0] SMP_NEG_ONE = 24'hFFFFFF;

    // Fixed-point units of the register formats.
    localparam logic [CFG_W-1:0] UNITY_Q16   = 17'd65536;
    localparam logic [CFG_W-1:0] ABOVE_UNITY = 17'h1FFFF;
    localparam logic [CFG_W-1:0] COEF_LOW    = 17'd1638;
    localparam logic [CFG_W-1:0] GAIN_UNITY  = 17'd4096;
    localparam logic [CFG_W-1:0] GAIN_LOW    = 17'd410;
    localparam logic [CFG_W-1:0] GAIN_HIGH   = 17'd40960;

    localparam longint STATE_HI = 64'sd2147483647;
    localparam longint STATE_LO = -64'sd2147483648;
    localparam longint OUT_HI   = 64'sd8388607;
    localparam longint OUT_LO   = -64'sd8388608;

    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 100;
    localparam int NUM_PHASES      = 8;
    localparam int PAIRS_PER_PHASE = 200;
    localparam int STEADY_PHASE    = 3;
    localparam int HOLD_AFTER      = 500;
    localparam int HOLD_CYCLES     = 400;
    // The long output hold-off, not the processing of a pair, dominates the limit.
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef enum logic {ROW_PAIR, ROW_WRITE} t_row_kind;

    typedef struct {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } t_stereo;

    typedef struct {
        t_row_kind                     kind;
        logic [sol_pkg::CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]              value;
        t_stereo                       samples;
        bit                            typed;
        t_stereo                       typed_result;
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [sol_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]              i_cfg_wdata;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [DATA_W-1:0]             s_axis_tdata;   // left_sample, right_sample
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [DATA_W-1:0]             m_axis_tdata;   // left_result, right_result

    // Shadow registers and filter state of the predictor.
    logic [CFG_W-1:0] drive_setting;
    logic [CFG_W-1:0] coef_setting;
    logic [15:0]      gain_setting;
    longint           left_filter_state;
    longint           right_filter_state;

    t_stereo expected_pairs[$];
    t_row    script[$];

    int  pairs_sent     = 0;
    int  directed_pairs = 0;
    int  results_seen   = 0;
    int  writes_done    = 0;
    int  errors         = 0;
    int  stall_cycles   = 0;
    bit  steady         = 1'b0;

    sqrt_overdrive_lowpass u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_row pair_row(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right);
        t_row r;
        r = '{kind: ROW_PAIR, index: '0, value: '0, samples: '{left, right},
              typed: 1'b0, typed_result: '{'0, '0}};
        return r;
    endfunction

    function automatic t_row known_row(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right,
                                       logic [SAMPLE_W-1:0] left_out,
                                       logic [SAMPLE_W-1:0] right_out);
        t_row r;
        r = pair_row(left, right);
        r.typed        = 1'b1;
        r.typed_result = '{left_out, right_out};
        return r;
    endfunction

    function automatic t_row write_row(logic [sol_pkg::CFG_IDX_W-1:0] index,
                                       logic [CFG_W-1:0] value);
        t_row r;
        r = pair_row('0, '0);
        r.kind  = ROW_WRITE;
        r.index = index;
        r.value = value;
        return r;
    endfunction

    // Mirror a register write into the shadow copy; unknown indexes change nothing.
    function automatic void shadow_write(logic [sol_pkg::CFG_IDX_W-1:0] index,
                                         logic [CFG_W-1:0] value);
        case (index)
            sol_pkg::CFG_DRIVE: drive_setting = value;
            sol_pkg::CFG_COEF:  coef_setting  = value;
            sol_pkg::CFG_GAIN:  gain_setting  = value[15:0];
            default: ;
        endcase
    endfunction

    // Integer square root, one result bit per step from the top down.
    function automatic longint floor_root(longint n);
        longint r;
        longint trial;
        int     k;
        r = 0;
        for (k = 24; k >= 0; k--) begin
            trial = r | (64'sd1 <<< k);
            if (trial * trial <= n) begin
                r = trial;
            end
        end
        return r;
    endfunction

    // One channel: root blend, lowpass update, gain and saturation.
    function automatic logic [SAMPLE_W-1:0] shape_channel(logic [SAMPLE_W-1:0] raw,
                                                          inout longint filt);
        longint x, mag, root, s, drive, coef, mix, y, o;
        x     = longint'($signed(raw));
        mag   = (x < 0) ? -x : x;
        root  = floor_root(mag <<< (SAMPLE_W - 1));
        s     = (x < 0) ? -root : root;
        drive = (drive_setting > UNITY_Q16) ? longint'(UNITY_Q16) : longint'(drive_setting);
        coef  = (coef_setting > UNITY_Q16) ? longint'(UNITY_Q16) : longint'(coef_setting);
        mix   = x + ((drive * (s - x)) >>> 16);
        y     = filt + ((coef * ((mix <<< 8) - filt)) >>> 16);
        if (y < STATE_LO) y = STATE_LO;
        if (y > STATE_HI) y = STATE_HI;
        filt = y;
        o = (y * longint'(gain_setting)) >>> (sol_pkg::GAIN_FRAC_BITS + 8);
        if (o < OUT_LO) o = OUT_LO;
        if (o > OUT_HI) o = OUT_HI;
        return o[SAMPLE_W-1:0];
    endfunction

    function automatic t_stereo shape_pair(t_stereo smp);
        t_stereo res;
        res.left  = shape_channel(smp.left, left_filter_state);
        res.right = shape_channel(smp.right, right_filter_state);
        return res;
    endfunction

    // Mostly full-range noise, with extremes and values near zero mixed in.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int near_zero;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return SMP_MAX;
                    1: return SMP_MIN;
                    2: return SMP_ZERO;
                    3: return SMP_ONE;
                    default: return SMP_NEG_ONE;
                endcase
            end
            1, 2: begin
                near_zero = int'($urandom_range(510)) - 255;
                return near_zero[SAMPLE_W-1:0];
            end
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(logic [sol_pkg::CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        shadow_write(index, value);
        writes_done++;
    endtask

    // Offer one stereo request, with random gaps, and record its expected result.
    task automatic send_pair(t_stereo smp, bit typed, t_stereo typed_result);
        t_stereo predicted;
        while (!steady && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {smp.right, smp.left};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predicted = shape_pair(smp);
        expected_pairs.push_back(typed ? typed_result : predicted);
        pairs_sent++;
        @(negedge i_clk);
    endtask

    // Stop sending and let every outstanding result drain before touching registers.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_pairs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Main sequence: directed table, then random phases with fresh settings each.
    initial begin
        t_stereo smp;
        logic [CFG_W-1:0] drive_pick, coef_pick, gain_pick;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        drive_setting      = '0;
        coef_setting       = UNITY_Q16;
        gain_setting       = 16'd4096;
        left_filter_state  = 0;
        right_filter_state = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        script = '{
            // Reset settings pass every sample through unchanged.
            known_row(SMP_ZERO, SMP_ZERO, SMP_ZERO, SMP_ZERO),
            known_row(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN),
            known_row(SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX),
            known_row(SMP_ONE, SMP_NEG_ONE, SMP_ONE, SMP_NEG_ONE),
            known_row(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA),
            // Full drive: the root of full scale is full scale.
            write_row(sol_pkg::CFG_DRIVE, UNITY_Q16),
            known_row(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN),
            pair_row(SMP_ONE, SMP_NEG_ONE),
            pair_row(SMP_ZERO, 24'h000400),
            // Drive above one behaves as full drive.
            write_row(sol_pkg::CFG_DRIVE, ABOVE_UNITY),
            pair_row(24'h123456, 24'hEDCBAA),
            // A zero coefficient freezes the filter.
            write_row(sol_pkg::CFG_COEF, '0),
            pair_row(SMP_MAX, SMP_MIN),
            pair_row(SMP_ZERO, SMP_ZERO),
            // Coefficient above one passes the mix; high gain saturates.
            write_row(sol_pkg::CFG_COEF, ABOVE_UNITY),
            write_row(sol_pkg::CFG_GAIN, GAIN_HIGH),
            known_row(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN),
            write_row(sol_pkg::CFG_GAIN, '0),
            known_row(SMP_MAX, SMP_MIN, SMP_ZERO, SMP_ZERO),
            // A write past the register list must leave the zero gain alone.
            write_row(CFG_UNUSED, ABOVE_UNITY),
            known_row(SMP_MAX, SMP_ZERO, SMP_ZERO, SMP_ZERO),
            // Gain keeps only its low 16 bits.
            write_row(sol_pkg::CFG_GAIN, ABOVE_UNITY),
            pair_row(24'h400000, 24'hFFFF00),
            // Slow filter, low gain, tiny values that must not be flushed.
            write_row(sol_pkg::CFG_DRIVE, '0),
            write_row(sol_pkg::CFG_COEF, COEF_LOW),
            write_row(sol_pkg::CFG_GAIN, GAIN_LOW),
            pair_row(SMP_ONE, SMP_NEG_ONE),
            pair_row(24'h000002, 24'hFFFFFE),
            pair_row(SMP_MAX, SMP_MIN),
            // Half drive, moderate filter.
            write_row(sol_pkg::CFG_DRIVE, 17'd32768),
            write_row(sol_pkg::CFG_COEF, 17'd20000),
            write_row(sol_pkg::CFG_GAIN, GAIN_UNITY),
            pair_row(24'h0000FF, 24'hFFFF00),
            pair_row(24'h7FFF00, 24'h800100)
        };

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                drain();
                write_reg(script[i].index, script[i].value);
            end else begin
                send_pair(script[i].samples, script[i].typed, script[i].typed_result);
                directed_pairs++;
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            // The first two phases sit at opposite corners of the settings.
            case (phase)
                0: begin
                    drive_pick = '0;
                    coef_pick  = COEF_LOW;
                    gain_pick  = GAIN_LOW;
                end
                1: begin
                    drive_pick = UNITY_Q16;
                    coef_pick  = UNITY_Q16;
                    gain_pick  = GAIN_HIGH;
                end
                default: begin
                    case ($urandom_range(5))
                        0: drive_pick = '0;
                        1: drive_pick = UNITY_Q16;
                        2: drive_pick = CFG_W'($urandom_range(131071, 65537));
                        default: drive_pick = CFG_W'($urandom_range(65536));
                    endcase
                    case ($urandom_range(7))
                        0: coef_pick = COEF_LOW;
                        1: coef_pick = UNITY_Q16;
                        2: coef_pick = '0;
                        3: coef_pick = CFG_W'($urandom_range(131071, 65537));
                        default: coef_pick = CFG_W'($urandom_range(65536, 1638));
                    endcase
                    case ($urandom_range(5))
                        0: gain_pick = GAIN_LOW;
                        1: gain_pick = GAIN_HIGH;
                        2: gain_pick = GAIN_UNITY;
                        3: gain_pick = CFG_W'($urandom_range(131071));
                        default: gain_pick = CFG_W'($urandom_range(40960, 410));
                    endcase
                end
            endcase
            write_reg(sol_pkg::CFG_DRIVE, drive_pick);
            write_reg(sol_pkg::CFG_COEF, coef_pick);
            write_reg(sol_pkg::CFG_GAIN, gain_pick);
            if ($urandom_range(3) == 0) begin
                write_reg(CFG_UNUSED, CFG_W'($urandom_range(131071)));
            end

            // One whole phase runs with no input gaps and the output always ready.
            steady = (phase == STEADY_PHASE);
            for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
                smp.left  = pick_sample();
                smp.right = pick_sample();
                send_pair(smp, 1'b0, '{'0, '0});
            end
            steady = 1'b0;
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Ran %0d directed and %0d random stereo pairs through %0d register writes,",
                 directed_pairs, pairs_sent - directed_pairs, writes_done);
        $display("with one long output hold-off; %0d results checked, %0d mismatches.",
                 results_seen, errors);
        if (errors == 0) begin
            $display("sqrt_overdrive_lowpass_test: PASS");
        end else begin
            $display("sqrt_overdrive_lowpass_test: FAIL");
        end
        $finish;
    end

    // Output side: random back-pressure, plus one long hold-off that fills the block.
    initial begin : sink
        bit held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 24);
        end
    end

    // Compare each result against the oldest expectation, field by field.
    always @(posedge i_clk) begin
        t_stereo want;
        t_stereo got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.left  = m_axis_tdata[SAMPLE_W-1:0];
            got.right = m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
            results_seen++;
            if (expected_pairs.size() == 0) begin
                errors++;
                $error("unexpected result: left_result %0d, right_result %0d",
                       $signed(got.left), $signed(got.right));
            end else begin
                want = expected_pairs.pop_front();
                if (got.left !== want.left) begin
                    errors++;
                    $error("left_result: expected %0d, actual %0d",
                           $signed(want.left), $signed(got.left));
                end
                if (got.right !== want.right) begin
                    errors++;
                    $error("right_result: expected %0d, actual %0d",
                           $signed(want.right), $signed(got.right));
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Timed out after %0d cycles without a transfer.", stall_cycles);
            $display("sqrt_overdrive_lowpass_test: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
